/* hdl/bccp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bccp_pkg;
  localparam int MaxBlocks = 1024;
  localparam int IdxW = 10;
  localparam int SumW = 20;
  localparam int CntW = 11;
  localparam int BpW = 13;
  localparam int MaxBlockPixels = 4096;
  localparam int ColW = 24;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegThreshold = 3'd1;
  localparam logic [2:0] RegRefRed = 3'd2;
  localparam logic [2:0] RegRefGreen = 3'd3;
  localparam logic [2:0] RegRefBlue = 3'd4;
  localparam logic [2:0] RegInvert = 3'd5;
  localparam logic [2:0] RegBlockPixels = 3'd6;

  typedef enum logic [3:0] {
    ST_ACC, ST_DIV, ST_RD, ST_NORM, ST_CMP, ST_PCT, ST_OUT, ST_CLR
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] threshold;
    logic [7:0] ref_red;
    logic [7:0] ref_green;
    logic [7:0] ref_blue;
    logic       invert_match;
    logic [12:0] block_pixels;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [SumW-1:0] dividend;
    logic [SumW-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

/* hdl/bccp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bccp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/bccp_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit a cycle
module bccp_div
  import bccp_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire div_req_t       req_i,
  output logic                done_o,
  output logic [SumW-1:0]     quot_o
);
  localparam int StepW = $clog2(SumW + 1);
  logic [SumW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [SumW:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[SumW-1]} - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d = '0; quo_d = req_i.dividend; cnt_d = StepW'(SumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[SumW]) rem_d = trial[SumW-1:0];
      else rem_d = {rem_q[SumW-2:0], quo_q[SumW-1]};
      quo_d = {quo_q[SumW-2:0], ~trial[SumW]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
    if (req_i.start) dvs_q <= req_i.divisor;
  end
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

/* hdl/bccp_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module bccp_cfg
  import bccp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        we_i,
  input  wire logic [2:0]  idx_i,
  input  wire logic [12:0] data_i,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 1'b0, threshold: 8'd10, ref_red: 8'd0, ref_green: 8'd0,
                 ref_blue: 8'd0, invert_match: 1'b0, block_pixels: 13'd256};
    end else if (we_i) begin
      unique case (idx_i)
        RegMode:        cfg_q.mode <= data_i[0];
        RegThreshold:   cfg_q.threshold <= data_i[7:0];
        RegRefRed:      cfg_q.ref_red <= data_i[7:0];
        RegRefGreen:    cfg_q.ref_green <= data_i[7:0];
        RegRefBlue:     cfg_q.ref_blue <= data_i[7:0];
        RegInvert:      cfg_q.invert_match <= data_i[0];
        RegBlockPixels: cfg_q.block_pixels <= data_i;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

/* hdl/block_color_change_percent_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// block color change detector
// s_axis carries one pixel item per handshake: tdata holds red, green, blue;
// tuser holds block_end, frame_end. m_axis gives one result item per block.
// config writes go through cfg_we_i, cfg_idx_i, cfg_data_i; the user must make them
// only while no block is in flight, and the block itself does not enforce it.
// a pixel that does not end a block is taken without closing the input. after a
// block-ending pixel the input stays closed while three averages run in the
// shared restoring divider, and then for store read, compare and output. in
// change mode, when both colors have nonzero intensity and the block fits
// the store, six share divisions follow the averages; a frame end adds a
// division for the hit percentage. the result is loaded as the input reopens.
// after reset the color store is cleared one entry a cycle, all 1024 entries,
// during which no pixel is taken.
// a stalled receiver holds the result in the output register; pixels of the
// next block are still taken, and its end waits in the last step until the
// register is free.
module block_color_change_percent_top
  import bccp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // pix_red, pix_green, pix_blue
  input  wire logic [1:0]  s_axis_tuser,  // block_end, frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // block_number, block_hit, hit_percent, pad
  output logic             m_axis_tuser   // frame_done
);
  cfg_t cfg;
  bccp_cfg u_cfg (.clk_i, .rst_ni, .we_i(cfg_we_i), .idx_i(cfg_idx_i),
                  .data_i(cfg_data_i), .cfg_o(cfg));

  state_e st_q, st_d;
  logic [SumW-1:0] sum_q [3];
  logic [SumW-1:0] sum_d [3];
  logic [7:0] avg_q [3];
  logic [7:0] old_q [3];
  logic [6:0] nn_q [3];   // new normalized
  logic [6:0] on_q [3];   // old normalized
  logic [2:0] step_q, step_d;
  logic [CntW-1:0] bcnt_q, hcnt_q;
  logic [IdxW-1:0] clr_q;
  logic fend_q, hit_q, ok_q;
  logic [IdxW-1:0] bnum_q;
  logic [6:0] pct_q;
  logic ovalid_q;
  logic [IdxW-1:0] out_bnum_q;
  logic out_hit_q, out_fend_q;
  logic [6:0] out_pct_q;
  logic out_ld;
  logic [ColW-1:0] rdata;
  logic ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [ColW-1:0] ram_wdata;
  div_req_t dreq;
  logic ddone;
  logic [SumW-1:0] dq;
  logic [BpW-1:0] dsr;
  logic [9:0] oi, ni;
  logic acc;

  bccp_ram #(.Width(ColW), .Depth(MaxBlocks)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(bcnt_q[IdxW-1:0]), .rdata_o(rdata));

  bccp_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dq));

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_ACC);
  assign out_ld = (st_q == ST_OUT) && (!ovalid_q || m_axis_tready);
  assign ni = 10'(avg_q[0]) + 10'(avg_q[1]) + 10'(avg_q[2]);
  assign oi = 10'(old_q[0]) + 10'(old_q[1]) + 10'(old_q[2]);

  always_comb begin
    dsr = cfg.block_pixels;
    if (dsr == '0) dsr = BpW'(1);
    if (dsr > BpW'(MaxBlockPixels)) dsr = BpW'(MaxBlockPixels);
  end

  function automatic logic [SumW-1:0] satadd(input logic [SumW-1:0] s, input logic [7:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + (SumW+1)'(v);
    return t[SumW] ? '1 : t[SumW-1:0];
  endfunction

  function automatic logic eqc(input logic [6:0] a, input logic [6:0] b,
                               input logic [7:0] th);
    logic [6:0] d;
    d = (a > b) ? a - b : b - a;
    return {1'b0, d} < th;
  endfunction

  // |a-b|*100/255 < th  <=>  |a-b|*100 < 255*th  (floor)
  function automatic logic eqr(input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] th);
    logic [7:0] d;
    logic [15:0] l, r;
    d = (a > b) ? a - b : b - a;
    l = 16'(d) * 16'd100;
    r = 16'(th) * 16'd255;
    return l < r;
  endfunction

  logic hit_c, er, eg, eb;
  always_comb begin
    er = eqr(cfg.ref_red, avg_q[0], cfg.threshold);
    eg = eqr(cfg.ref_green, avg_q[1], cfg.threshold);
    eb = eqr(cfg.ref_blue, avg_q[2], cfg.threshold);
    if (cfg.mode) hit_c = (er && eg && eb) ^ cfg.invert_match;
    else if (oi == '0 || ni == '0) hit_c = 1'b0;
    else hit_c = !(eqc(nn_q[0], on_q[0], cfg.threshold) &&
                   eqc(nn_q[1], on_q[1], cfg.threshold) &&
                   eqc(nn_q[2], on_q[2], cfg.threshold));
    hit_c = hit_c && ok_q;
  end

  // counters as they stand after this block
  logic [CntW-1:0] n_nx, h_nx;
  assign n_nx = bcnt_q + CntW'(bcnt_q != '1);
  assign h_nx = hcnt_q + CntW'(hit_c && hcnt_q != '1);

  logic [SumW-1:0] pct_num;
  logic [CntW-1:0] hsat;
  always_comb begin
    hsat = (h_nx > n_nx) ? n_nx : h_nx;
    pct_num = SumW'(hsat) * SumW'(100) + SumW'(n_nx >> 1);
  end

  // ST_DIV steps 0..2 average; ST_NORM steps 7, 1, 2 new shares, 3..5 old shares
  logic [1:0] ch;
  always_comb begin
    st_d = st_q; step_d = step_q;
    dreq = '0;
    ram_we = 1'b0; ram_waddr = bcnt_q[IdxW-1:0];
    ram_wdata = {avg_q[0], avg_q[1], avg_q[2]};
    ch = step_q[1:0];
    for (int i = 0; i < 3; i++) sum_d[i] = sum_q[i];
    unique case (st_q)
      ST_CLR: begin
        ram_we = 1'b1; ram_waddr = clr_q; ram_wdata = '0;
        if (clr_q == '1) st_d = ST_ACC;
      end
      ST_ACC: begin
        if (acc) begin
          sum_d[0] = satadd(sum_q[0], s_axis_tdata[7:0]);
          sum_d[1] = satadd(sum_q[1], s_axis_tdata[15:8]);
          sum_d[2] = satadd(sum_q[2], s_axis_tdata[23:16]);
          if (s_axis_tuser != 2'b00) begin
            st_d = ST_DIV; step_d = '0;
            dreq.start = 1'b1; dreq.dividend = sum_d[0]; dreq.divisor = SumW'(dsr);
          end
        end
      end
      ST_DIV: begin
        if (ddone) begin
          if (step_q == 3'd2) begin
            st_d = ST_RD;
            for (int i = 0; i < 3; i++) sum_d[i] = '0;
          end else begin
            step_d = step_q + 1'b1;
            dreq.start = 1'b1; dreq.divisor = SumW'(dsr);
            dreq.dividend = sum_q[2'(step_q + 1'b1)];
          end
        end
      end
      ST_RD: begin
        // stored color is on the read port this cycle
        st_d = ST_NORM; step_d = '0;
      end
      ST_NORM: begin
        // step 7 marks the first new-color division in flight
        if (cfg.mode || !ok_q || oi == '0 || ni == '0) begin
          st_d = ST_CMP;
        end else begin
          if (step_q == 3'd0 && !ddone) begin
            dreq.start = 1'b1; dreq.dividend = SumW'(avg_q[0]) * SumW'(100);
            dreq.divisor = SumW'(ni);
            step_d = 3'd7;
          end else if (ddone) begin
            if (step_q == 3'd5) st_d = ST_CMP;
            else begin
              step_d = (step_q == 3'd7) ? 3'd1 : step_q + 1'b1;
              dreq.start = 1'b1;
              if (step_d < 3'd3) begin
                dreq.dividend = SumW'(avg_q[step_d[1:0]]) * SumW'(100);
                dreq.divisor = SumW'(ni);
              end else begin
                dreq.dividend = SumW'(old_q[2'(step_d - 3'd3)]) * SumW'(100);
                dreq.divisor = SumW'(oi);
              end
            end
          end
        end
      end
      ST_CMP: begin
        ram_we = ok_q;
        if (fend_q) begin
          st_d = ST_PCT;
          dreq.start = 1'b1;
          dreq.dividend = pct_num;
          dreq.divisor = SumW'(n_nx);
        end else st_d = ST_OUT;
      end
      ST_PCT: if (ddone) st_d = ST_OUT;
      ST_OUT: if (out_ld) st_d = ST_ACC;
      default: st_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLR; step_q <= '0; clr_q <= '0;
      bcnt_q <= '0; hcnt_q <= '0; ovalid_q <= 1'b0; fend_q <= 1'b0;
      out_bnum_q <= '0; out_hit_q <= 1'b0; out_pct_q <= '0; out_fend_q <= 1'b0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      st_q <= st_d; step_q <= step_d;
      for (int i = 0; i < 3; i++) sum_q[i] <= sum_d[i];
      if (st_q == ST_CLR) clr_q <= clr_q + 1'b1;
      if (acc) fend_q <= s_axis_tuser[1];
      if (out_ld) begin
        ovalid_q <= 1'b1;
        out_bnum_q <= bnum_q;
        out_hit_q <= hit_q;
        out_pct_q <= pct_q;
        out_fend_q <= fend_q;
        if (fend_q) begin
          bcnt_q <= '0; hcnt_q <= '0;
        end
      end else if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (st_q == ST_CMP) begin
        bcnt_q <= n_nx;
        hcnt_q <= h_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DIV && ddone) avg_q[ch] <= (dq > SumW'(255)) ? 8'hFF : dq[7:0];
    if (st_q == ST_RD) begin
      ok_q <= bcnt_q < CntW'(MaxBlocks);
      bnum_q <= bcnt_q[IdxW-1:0];
      old_q[0] <= rdata[23:16];
      old_q[1] <= rdata[15:8];
      old_q[2] <= rdata[7:0];
    end
    if (st_q == ST_NORM && ddone) begin
      if (step_q == 3'd7) nn_q[0] <= dq[6:0];
      else if (step_q < 3'd3) nn_q[2'(step_q)] <= dq[6:0];
      else on_q[2'(step_q - 3'd3)] <= dq[6:0];
    end
    if (st_q == ST_CMP) begin
      hit_q <= hit_c;
      pct_q <= '0;
    end
    if (st_q == ST_PCT && ddone) pct_q <= (dq > SumW'(100)) ? 7'd100 : dq[6:0];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {6'd0, out_pct_q, out_hit_q, out_bnum_q};
  assign m_axis_tuser = out_fend_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLR) |-> !s_axis_tready)
    else $error("pixel taken during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:11] <= 7'd100))
    else $error("percent out of range");
endmodule
`default_nettype wire
